FILE: src/assert_macros.svh
// Concurrent assertion macros used by the RTL module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checks that the property holds at every rising clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: property does not hold");
// Checks that the condition never becomes true out of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed: forbidden condition seen");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

FILE: src/sha256_pkg.sv
// Constants, types and round functions of the SHA-256 engine.
package sha256_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned NumWords = 8;
  localparam int unsigned WinWords = 16;
  localparam int unsigned NumRounds = 64;
  localparam logic [7:0]  PadMarker = 8'h80;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [4:0] {
    ST_ABSORB = 5'b00001,
    ST_PAD    = 5'b00010,
    ST_ROUND  = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_OUT    = 5'b10000
  } state_e;

  localparam word_t InitHash [NumWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t v, input int unsigned n);
    rotr = (v >> n) | (v << (WordW - n));
  endfunction

  function automatic word_t big_sigma0(input word_t v);
    big_sigma0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t v);
    big_sigma1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t v);
    small_sigma0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t v);
    small_sigma1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
  endfunction

endpackage

FILE: src/sha256_hash_engine_unit.sv
// SHA-256 engine: byte intake, padding, iterative compression and digest output.
//
//  channel   | dir | tdata                          | tuser        | tlast
//  ----------+-----+--------------------------------+--------------+---------------
//  s_axis    | in  | [7:0] msg_byte                 | byte_present | end_of_message
//  m_axis    | out | [31:0] digest_word,            | -            | last_word
//            |     | [34:32] word_number, [39:35] 0 |              |
//
// While the engine collects bytes it takes a new item whenever one is offered. When the 64th byte
// of a block arrives, the shared round unit runs all 64 rounds, one round per cycle,
// followed by a chaining update that folds the working variables into the chaining value.
// A final item makes the engine write padding bytes up to the block end and compress
// each padded block (one or two blocks), then it sends the eight digest words.
// s_axis_tready_o is low from a block's last byte or a final item until the engine
// collects again; the output waits as long as m_axis_tready_i stays low.
// Reset is asynchronous.
`include "assert_macros.svh"

module sha256_hash_engine_unit
  import sha256_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] msg_byte
  input  logic        s_axis_tuser_i,   // [0] byte_present
  input  logic        s_axis_tlast_i,   // end_of_message
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] digest_word, [34:32] word_number, rest zero
  output logic        m_axis_tlast_o    // last_word
);

  state_e      state_q, state_d;
  state_e      ret_q, ret_d;           // where to go after the chaining update
  word_t       hash_q [NumWords];
  word_t       hash_d [NumWords];
  word_t       wv_q   [NumWords];      // working variables a..h
  word_t       wv_d   [NumWords];
  word_t       win_q  [WinWords];      // message schedule window, entry 0 is oldest
  word_t       win_d  [WinWords];
  logic [63:0] byte_cnt_q, byte_cnt_d;
  logic [5:0]  pos_q, pos_d;           // bytes in the current block
  logic [5:0]  round_q, round_d;
  logic [2:0]  out_idx_q, out_idx_d;
  logic        pad_first_q, pad_first_d;
  logic        wrap_q, wrap_d;         // marker byte landed too late for the length

  logic        in_accept, out_accept;
  logic        shift_byte;
  logic [7:0]  shift_val;
  logic [7:0]  pad_byte;
  logic [63:0] len_bits;
  logic [2:0]  len_sel;
  logic        marker_late;
  word_t       t1, t2, sched_new;

  assign in_accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_accept = m_axis_tvalid_o && m_axis_tready_i;

  assign s_axis_tready_o = (state_q == ST_ABSORB);
  assign m_axis_tvalid_o = (state_q == ST_OUT);
  assign m_axis_tdata_o  = {5'b0, out_idx_q, hash_q[out_idx_q]};
  assign m_axis_tlast_o  = (out_idx_q == 3'd7);

  // Padding byte: the marker first, then zeros, with the big-endian bit length in
  // the last eight positions of the final block.
  assign len_bits    = {byte_cnt_q[60:0], 3'b000};
  assign len_sel     = 3'd7 - pos_q[2:0];
  assign marker_late = pad_first_q && (pos_q[5:3] == 3'b111);

  always_comb begin
    if (pad_first_q) begin
      pad_byte = PadMarker;
    end else if (pos_q[5:3] == 3'b111 && !wrap_q) begin
      pad_byte = len_bits[{len_sel, 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // One SHA-256 round and one schedule word per cycle.
  always_comb begin
    t1 = wv_q[7] + big_sigma1(wv_q[4]) + ((wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]))
       + RoundK[round_q] + win_q[0];
    t2 = big_sigma0(wv_q[0])
       + ((wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]));
    sched_new = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];
  end

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    hash_d      = hash_q;
    wv_d        = wv_q;
    win_d       = win_q;
    byte_cnt_d  = byte_cnt_q;
    pos_d       = pos_q;
    round_d     = round_q;
    out_idx_d   = out_idx_q;
    pad_first_d = pad_first_q;
    wrap_d      = wrap_q;
    shift_byte  = 1'b0;
    shift_val   = pad_byte;

    unique case (state_q)
      ST_ABSORB: begin
        if (in_accept) begin
          if (s_axis_tlast_i) begin
            pad_first_d = 1'b1;
            wrap_d      = 1'b0;
          end
          if (s_axis_tuser_i) begin
            shift_byte = 1'b1;
            shift_val  = s_axis_tdata_i;
            byte_cnt_d = byte_cnt_q + 64'd1;
            pos_d      = pos_q + 6'd1;
          end
          if (s_axis_tuser_i && pos_q == 6'd63) begin
            state_d = ST_ROUND;
            ret_d   = s_axis_tlast_i ? ST_PAD : ST_ABSORB;
          end else if (s_axis_tlast_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        shift_byte  = 1'b1;
        pos_d       = pos_q + 6'd1;
        pad_first_d = 1'b0;
        if (marker_late) begin
          wrap_d = 1'b1;
        end
        if (pos_q == 6'd63) begin
          state_d = ST_ROUND;
          ret_d   = (wrap_q || marker_late) ? ST_PAD : ST_OUT;
          wrap_d  = 1'b0;
        end
      end
      ST_ROUND: begin
        wv_d[7] = wv_q[6];
        wv_d[6] = wv_q[5];
        wv_d[5] = wv_q[4];
        wv_d[4] = wv_q[3] + t1;
        wv_d[3] = wv_q[2];
        wv_d[2] = wv_q[1];
        wv_d[1] = wv_q[0];
        wv_d[0] = t1 + t2;
        for (int i = 0; i < WinWords - 1; i++) begin
          win_d[i] = win_q[i+1];
        end
        win_d[WinWords-1] = sched_new;
        round_d = round_q + 6'd1;
        if (round_q == 6'd63) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        for (int i = 0; i < NumWords; i++) begin
          hash_d[i] = hash_q[i] + wv_q[i];
        end
        out_idx_d = 3'd0;
        state_d   = ret_q;
      end
      ST_OUT: begin
        if (out_accept) begin
          out_idx_d = out_idx_q + 3'd1;
          if (out_idx_q == 3'd7) begin
            hash_d     = InitHash;
            byte_cnt_d = '0;
            pos_d      = '0;
            state_d    = ST_ABSORB;
          end
        end
      end
      default: begin
        state_d = ST_ABSORB;
      end
    endcase

    // Bytes enter the window at the young end, so the oldest word is big-endian.
    if (shift_byte) begin
      for (int i = 0; i < WinWords - 1; i++) begin
        win_d[i] = {win_q[i][23:0], win_q[i+1][31:24]};
      end
      win_d[WinWords-1] = {win_q[WinWords-1][23:0], shift_val};
    end

    // The working variables start from the chaining value of each block.
    if (state_d == ST_ROUND && state_q != ST_ROUND) begin
      wv_d    = hash_q;
      round_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ABSORB;
      ret_q       <= ST_ABSORB;
      hash_q      <= InitHash;
      byte_cnt_q  <= '0;
      pos_q       <= '0;
      round_q     <= '0;
      out_idx_q   <= '0;
      pad_first_q <= 1'b0;
      wrap_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      hash_q      <= hash_d;
      byte_cnt_q  <= byte_cnt_d;
      pos_q       <= pos_d;
      round_q     <= round_d;
      out_idx_q   <= out_idx_d;
      pad_first_q <= pad_first_d;
      wrap_q      <= wrap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wv_q  <= wv_d;
    win_q <= win_d;
  end

  // Intake and digest output never overlap.
  `ASSERT_NEVER(a_no_overlap, clk_i, rst_ni, s_axis_tready_o && m_axis_tvalid_o)
  // Compression always starts on a block boundary.
  `ASSERT_ALWAYS(a_round_on_boundary, clk_i, rst_ni,
                 (state_q != ST_ROUND && state_d == ST_ROUND) |-> pos_d == 6'd0)
  // The round loop runs all 64 rounds before the chaining update.
  `ASSERT_ALWAYS(a_round_run, clk_i, rst_ni,
                 (state_q == ST_ROUND && round_q != 6'd63) |=> state_q == ST_ROUND)
  // After the last digest word the engine is clear for the next message.
  `ASSERT_ALWAYS(a_clear_after_digest, clk_i, rst_ni,
                 (out_accept && m_axis_tlast_o) |=>
                 (state_q == ST_ABSORB && byte_cnt_q == 64'd0 && pos_q == 6'd0))

endmodule

FILE: dv/tb_sha256_hash_engine_unit.sv
// Self-checking testbench for the SHA-256 hash engine with a bit-exact digest predictor.
module tb_sha256_hash_engine_unit;
  import sha256_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The run is cut off here if the engine stops making progress.
  localparam int unsigned LimitCycles = 300_000;
  // Cycles of quiet after the last digest word, well past the padding and output latency.
  localparam int unsigned TailCycles = 300;
  // Length of the one long output hold-off.
  localparam int unsigned HoldCycles = 300;
  // Percentage of cycles in which either side idles outside the quiet windows.
  localparam int unsigned IdlePct = 20;
  // Number of message-carrying items the random part fills up to.
  localparam int unsigned ItemTarget = 170;

  // One entry of the stimulus queue. An entry with wait_drain set is not sent:
  // it makes the sender stop until every digest word has come out.
  typedef struct {
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       end_of_message;
    bit         wait_drain;
  } msg_item_t;

  // One expected digest word as it should appear on the output stream.
  typedef struct packed {
    word_t      digest_word;
    logic [2:0] word_number;
    logic       last_word;
  } digest_entry_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;   // [7:0] msg_byte
  logic        s_axis_tuser_i = 1'b0; // [0] byte_present
  logic        s_axis_tlast_i = 1'b0; // end_of_message
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;        // [31:0] digest_word, [34:32] word_number, rest zero
  logic        m_axis_tlast_o;        // last_word

  msg_item_t     pending_q[$];
  digest_entry_t digest_q[$];

  // Predictor state: chaining value, block buffer and running byte count.
  word_t       hash_state [NumWords];
  logic [7:0]  blk_bytes  [64];
  logic [63:0] msg_len;

  int unsigned items_queued  = 0;
  int unsigned msg_count     = 0;
  int unsigned items_taken   = 0;
  int unsigned words_seen    = 0;
  int unsigned fail_count    = 0;
  int unsigned cycle_count   = 0;
  int unsigned stall_left    = 0;
  bit          stall_done    = 1'b0;
  int unsigned two_block_pad = 0;

  sha256_hash_engine_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Rotate right by taking the low half of the word placed twice side by side.
  function automatic word_t ror(input word_t v, input int unsigned n);
    logic [63:0] twice;
    twice = {v, v} >> n;
    return twice[31:0];
  endfunction

  // Run the 64 rounds on the buffered block and fold the result into the chaining value.
  function automatic void fold_block();
    word_t sched [64];
    word_t v [8];
    word_t t1, t2, lo, hi;
    int    i;
    for (i = 0; i < 16; i++) begin
      sched[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    end
    for (i = 16; i < 64; i++) begin
      lo = ror(sched[i-15], 7) ^ ror(sched[i-15], 18) ^ (sched[i-15] >> 3);
      hi = ror(sched[i-2], 17) ^ ror(sched[i-2], 19) ^ (sched[i-2] >> 10);
      sched[i] = sched[i-16] + lo + sched[i-7] + hi;
    end
    for (i = 0; i < 8; i++) begin
      v[i] = hash_state[i];
    end
    for (i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[i] + sched[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (i = 0; i < 8; i++) begin
      hash_state[i] = hash_state[i] + v[i];
    end
  endfunction

  // Bring the predictor back to the state of an engine between messages.
  function automatic void restart_hash();
    int i;
    for (i = 0; i < NumWords; i++) begin
      hash_state[i] = InitHash[i];
    end
    msg_len = '0;
  endfunction

  // Absorb one accepted item; a final item pads the message and queues its eight digest words.
  function automatic void absorb_item(input logic [7:0] b, input logic present,
                                      input logic last);
    logic [63:0]   bit_len;
    int unsigned   pos;
    int unsigned   i;
    digest_entry_t ent;
    if (present) begin
      blk_bytes[msg_len[5:0]] = b;
      msg_len = msg_len + 64'd1;
      if (msg_len[5:0] == 6'd0) begin
        fold_block();
      end
    end
    if (last) begin
      bit_len = msg_len << 3;
      pos = 32'(msg_len[5:0]);
      blk_bytes[pos] = PadMarker;
      pos++;
      // The length field no longer fits, so the padding spills into a second block.
      if (pos > 56) begin
        two_block_pad++;
        while (pos < 64) begin
          blk_bytes[pos] = 8'h00;
          pos++;
        end
        fold_block();
        pos = 0;
      end
      while (pos < 56) begin
        blk_bytes[pos] = 8'h00;
        pos++;
      end
      for (i = 0; i < 8; i++) begin
        blk_bytes[56+i] = bit_len[63-8*i -: 8];
      end
      fold_block();
      for (i = 0; i < NumWords; i++) begin
        ent.digest_word = hash_state[i];
        ent.word_number = i[2:0];
        ent.last_word   = (i == NumWords - 1);
        digest_q.insert(digest_q.size(), ent);
      end
      restart_hash();
    end
  endfunction

  task automatic push_item(input logic [7:0] b, input logic present, input logic last);
    msg_item_t it;
    it.msg_byte       = b;
    it.byte_present   = present;
    it.end_of_message = last;
    it.wait_drain     = 1'b0;
    pending_q.insert(pending_q.size(), it);
    if (present || last) begin
      items_queued++;
    end
    if (last) begin
      msg_count++;
    end
  endtask

  task automatic push_drain();
    msg_item_t it;
    it.msg_byte       = '0;
    it.byte_present   = 1'b0;
    it.end_of_message = 1'b0;
    it.wait_drain     = 1'b1;
    pending_q.insert(pending_q.size(), it);
  endtask

  // Queue a message of random bytes. It ends either on its last byte or on an
  // empty tail item, and empty items with a random byte are sprinkled in as noise.
  task automatic queue_message(input int unsigned len, input bit tail_item);
    int unsigned k;
    bit          tail;
    tail = tail_item || (len == 0);
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 99) < 5) begin
        push_item(8'($urandom), 1'b0, 1'b0);
      end
      push_item(8'($urandom), 1'b1, !tail && (k == len - 1));
    end
    if (tail) begin
      push_item(8'($urandom), 1'b0, 1'b1);
    end
  endtask

  // Sender: when the item is taken or none is pending, offers the next queued item unless it idles
  // at random or waits at a drain entry; every accepted item goes to the predictor at that same edge.
  always @(posedge clk_i or negedge rst_ni) begin : sender_proc
    msg_item_t nxt;
    bit        take;
    bit        go;
    bit        calm;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      s_axis_tuser_i  <= 1'b0;
      s_axis_tlast_i  <= 1'b0;
    end else begin
      take = s_axis_tvalid_i && s_axis_tready_o;
      if (take) begin
        absorb_item(s_axis_tdata_i, s_axis_tuser_i, s_axis_tlast_i);
        items_taken++;
      end
      if (!s_axis_tvalid_i || take) begin
        go   = 1'b0;
        calm = (items_taken >= 100) && (items_taken < 160);
        if (pending_q.size() > 0 && pending_q[0].wait_drain) begin
          // Pause here until the engine has delivered everything it owes.
          if (digest_q.size() == 0) begin
            void'(pending_q.pop_front());
          end
        end else if (pending_q.size() > 0 && (calm || $urandom_range(0, 99) >= IdlePct)) begin
          nxt = pending_q.pop_front();
          go  = 1'b1;
        end
        if (go) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= nxt.msg_byte;
          s_axis_tuser_i  <= nxt.byte_present;
          s_axis_tlast_i  <= nxt.end_of_message;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted digest word against the oldest expectation and
  // drives ready with random stalls, one long hold-off and a window without stalls.
  always @(posedge clk_i or negedge rst_ni) begin : receiver_proc
    digest_entry_t want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (digest_q.size() == 0) begin
          $error("digest word %08h arrived with nothing expected", m_axis_tdata_o[31:0]);
          fail_count++;
        end else begin
          want = digest_q.pop_front();
          if (m_axis_tdata_o[31:0] !== want.digest_word) begin
            $error("digest_word: expected %08h, got %08h", want.digest_word,
                   m_axis_tdata_o[31:0]);
            fail_count++;
          end
          if (m_axis_tdata_o[34:32] !== want.word_number) begin
            $error("word_number: expected %0d, got %0d", want.word_number,
                   m_axis_tdata_o[34:32]);
            fail_count++;
          end
          if (m_axis_tlast_o !== want.last_word) begin
            $error("last_word: expected %0b, got %0b", want.last_word, m_axis_tlast_o);
            fail_count++;
          end
        end
        words_seen++;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else if (!stall_done && words_seen >= 12) begin
        // Hold the output in the middle of a digest while later messages keep coming,
        // so the engine has to stop taking input.
        stall_done = 1'b1;
        stall_left = HoldCycles;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ((words_seen >= 40) && (words_seen < 64))
                           || ($urandom_range(0, 99) >= IdlePct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LimitCycles) begin
      $display("Timeout after %0d cycles with %0d digest words outstanding",
               cycle_count, digest_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus_proc
    int unsigned boundary_len [6];
    int unsigned pick;
    int unsigned len;
    bit          drain_queued;
    boundary_len = '{55, 56, 57, 63, 64, 65};
    drain_queued = 1'b0;
    restart_hash();
    for (int i = 0; i < 64; i++) begin
      blk_bytes[i] = 8'h00;
    end

    // Directed part. An empty message made of a single empty tail item.
    push_item(8'hff, 1'b0, 1'b1);
    // An empty item, then the classic three-byte message ending on its last byte.
    push_item(8'h5a, 1'b0, 1'b0);
    push_item(8'h61, 1'b1, 1'b0);
    push_item(8'h62, 1'b1, 1'b0);
    push_item(8'h63, 1'b1, 1'b1);
    // Extreme byte values with an empty item between them and an empty tail at the end.
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'haa, 1'b0, 1'b0);
    push_item(8'hff, 1'b1, 1'b0);
    push_item(8'h55, 1'b0, 1'b1);
    // A single byte equal to the padding marker.
    push_item(PadMarker, 1'b1, 1'b1);
    push_drain();

    // Random part: mostly short messages, many lengths right at the padding boundaries,
    // some of 13 to 54 bytes and a few of 100 to 130 bytes. The last messages are cut
    // short so the total stays close to the target.
    while (items_queued < ItemTarget || msg_count < 10) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        len = $urandom_range(0, 12);
      end else if (pick < 8) begin
        len = boundary_len[$urandom_range(0, 5)];
      end else if (pick == 8) begin
        len = $urandom_range(100, 130);
      end else begin
        len = $urandom_range(13, 54);
      end
      if (items_queued + len + 1 > ItemTarget) begin
        len = (items_queued + 1 < ItemTarget) ? ItemTarget - 1 - items_queued : 0;
      end
      queue_message(len, $urandom_range(0, 99) < 30);
      if (!drain_queued && msg_count >= 8) begin
        push_drain();
        drain_queued = 1'b1;
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || s_axis_tvalid_i) @(posedge clk_i);
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("Hashed %0d messages from %0d accepted items, %0d of them padded over two blocks;",
             msg_count, items_taken, two_block_pad);
    $display("checked %0d digest words under random stalls and one long output hold-off.",
             words_seen);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
